// ----- rtl/hamming_encode_and_syndrome_macros.svh -----
// ----------------------------------------------------------------------------
// hamming_encode_and_syndrome_macros
// Assertion macros for the Hamming encoder and syndrome checker.
// ----------------------------------------------------------------------------
`ifndef HAMMING_ENCODE_AND_SYNDROME_MACROS_SVH
`define HAMMING_ENCODE_AND_SYNDROME_MACROS_SVH

`ifndef SYNTHESIS

`define HES_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hamming block check failed");

`define HES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hamming block check failed");

`else

`define HES_ASSERT_SAME(label, ante, cons)

`define HES_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/hes_pkg.sv -----
// ----------------------------------------------------------------------------
// hes_pkg
// Shared widths, operation codes and code geometry helpers.
// ----------------------------------------------------------------------------
package hes_pkg;

  localparam int NIBBLES  = 8;
  localparam int DIGIT_W  = 4;
  localparam int DATA_W   = 32;
  localparam int CODE_W   = 38;
  localparam int POS_W    = 6;
  localparam int CHECK_N  = 6;
  localparam int CHECK_W  = 3;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_CHECK  = 1'b1
  } op_t;

  typedef struct packed {
    logic [POS_W-1:0]   len;
    logic [CHECK_W-1:0] checks;
    logic [POS_W-1:0]   data_bits;
  } geom_t;

  function automatic geom_t code_geom(input logic [DIGIT_W-1:0] digits);
    int    d;
    int    n;
    int    r;
    geom_t g;
    d = int'(digits);
    if (d < 1) d = 1;
    if (d > NIBBLES) d = NIBBLES;
    n = 4 * d;
    r = 7;
    for (int i = 7; i >= 0; i--) begin
      if ((1 << i) >= n + i + 1) r = i;
    end
    g.len       = POS_W'(n + r);
    g.checks    = CHECK_W'(r);
    g.data_bits = POS_W'(n);
    return g;
  endfunction

  function automatic logic [CODE_W-1:0] cover_mask(input int k);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      m[p-1] = ((p >> k) & 1) != 0;
    end
    return m;
  endfunction

endpackage

// ----- rtl/hes_core.sv -----
// ----------------------------------------------------------------------------
// hes_core
// Data spreading, group parity trees, check bit insertion and syndrome.
// ----------------------------------------------------------------------------
module hes_core (
  input  logic                          op,
  input  logic [hes_pkg::DIGIT_W-1:0]   digit_count,
  input  logic [hes_pkg::DATA_W-1:0]    data_value,
  input  logic [hes_pkg::CODE_W-1:0]    received_word,
  input  logic                          odd_sel,
  output logic [hes_pkg::CODE_W-1:0]    code_word,
  output logic [hes_pkg::POS_W-1:0]     error_position,
  output logic [hes_pkg::POS_W-1:0]     code_length
);
  import hes_pkg::*;

  geom_t               geom;
  logic [DATA_W-1:0]   data_mask;
  logic [CODE_W-1:0]   len_mask;
  logic [DATA_W-1:0]   data_used;
  logic [CODE_W-1:0]   spread;
  logic [CODE_W-1:0]   word_in;
  logic [CHECK_N-1:0]  fail;
  logic [CODE_W-1:0]   check_bits;

  assign geom      = code_geom(digit_count);
  assign data_mask = DATA_W'((64'd1 << geom.data_bits) - 64'd1);
  assign len_mask  = CODE_W'((64'd1 << geom.len) - 64'd1);
  assign data_used = data_value & data_mask;

  always_comb begin
    int x;
    spread = '0;
    x      = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        spread[p-1] = data_used[x];
        x++;
      end
    end
  end

  assign word_in = (op == OP_CHECK) ? (received_word & len_mask) : spread;

  always_comb begin
    check_bits = '0;
    for (int k = 0; k < CHECK_N; k++) begin
      fail[k] = (^(word_in & cover_mask(k)) ^ odd_sel) && (k < int'(geom.checks));
      check_bits[(1 << k) - 1] = fail[k];
    end
  end

  assign code_word      = (op == OP_CHECK) ? '0 : (word_in | check_bits);
  assign error_position = (op == OP_CHECK) ? fail : '0;
  assign code_length    = geom.len;

endmodule

// ----- rtl/hamming_encode_and_syndrome.sv -----
// ----------------------------------------------------------------------------
// hamming_encode_and_syndrome
// Hamming single-error-correcting encoder and syndrome checker for words of
// one to eight hex digits. Each request either encodes data_value (op 0)
// into a code word with check bits at the power-of-two positions, or checks
// received_word (op 1) and returns the 1-based failing position, 0 if none.
// Group parity is odd or even as set through the configuration channel
// (odd after reset). A new request is taken every cycle while the output
// is not stalled. A request is held in the input register while the six
// parity trees over the 38-bit word work on it, and its result is then
// registered in the result register that drives the outputs. Both registers
// hold under back-pressure.
// ----------------------------------------------------------------------------
`include "hamming_encode_and_syndrome_macros.svh"

module hamming_encode_and_syndrome (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          odd_parity,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [hes_pkg::DIGIT_W-1:0]   digit_count,
  input  logic [hes_pkg::DATA_W-1:0]    data_value,
  input  logic [hes_pkg::CODE_W-1:0]    received_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hes_pkg::CODE_W-1:0]    code_word,
  output logic [hes_pkg::POS_W-1:0]     error_position,
  output logic [hes_pkg::POS_W-1:0]     code_length
);
  import hes_pkg::*;

  logic                 odd_sel;
  logic                 s1_valid;
  logic                 s1_op;
  logic [DIGIT_W-1:0]   s1_digits;
  logic [DATA_W-1:0]    s1_data;
  logic [CODE_W-1:0]    s1_recv;
  logic                 s2_ready;
  logic [CODE_W-1:0]    core_word;
  logic [POS_W-1:0]     core_syndrome;
  logic [POS_W-1:0]     core_len;

  assign cfg_ready = 1'b1;
  assign s2_ready  = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      odd_sel <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      odd_sel <= odd_parity;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_op     <= op;
      s1_digits <= digit_count;
      s1_data   <= data_value;
      s1_recv   <= received_word;
    end
  end

  hes_core u_core (
    .op             (s1_op),
    .digit_count    (s1_digits),
    .data_value     (s1_data),
    .received_word  (s1_recv),
    .odd_sel        (odd_sel),
    .code_word      (core_word),
    .error_position (core_syndrome),
    .code_length    (core_len)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && s2_ready) begin
      code_word      <= core_word;
      error_position <= core_syndrome;
      code_length    <= core_len;
    end
  end

  `HES_ASSERT_SAME(a_encode_no_syndrome, out_valid && code_word != '0, error_position == '0)
  `HES_ASSERT_SAME(a_length_range, out_valid, code_length >= POS_W'(7) && code_length <= POS_W'(CODE_W))
  `HES_ASSERT_NEXT(a_advance, s1_valid && s2_ready, out_valid)

endmodule

// ----- bench/tb_hamming_encode_and_syndrome.sv -----
// ----------------------------------------------------------------------------
// tb_hamming_encode_and_syndrome
// Self-checking bench for the Hamming encoder and syndrome checker. Requests
// are encoded or checked by a predictor in the bench, and every result is
// compared field by field in order. Coverage: every digit count (including
// saturated ones), both parity settings, clean and corrupted code words, junk
// above the code length, random back-pressure and a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_hamming_encode_and_syndrome;
  timeunit 1ns;
  timeprecision 1ps;

  import hes_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_MAX   = 10;

  typedef struct packed {
    logic [CODE_W-1:0] code_word;
    logic [POS_W-1:0]  error_position;
    logic [POS_W-1:0]  code_length;
  } hamming_result_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic                odd_parity     = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                op             = OP_ENCODE;
  logic [DIGIT_W-1:0]  digit_count    = '0;
  logic [DATA_W-1:0]   data_value     = '0;
  logic [CODE_W-1:0]   received_word  = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [CODE_W-1:0]   code_word;
  logic [POS_W-1:0]    error_position;
  logic [POS_W-1:0]    code_length;

  hamming_result_t results_due[$];
  hamming_result_t got_result;
  hamming_result_t due_result;
  bit              parity_odd   = 1'b1;
  bit              no_idle      = 1'b0;
  int              fail_count   = 0;
  int              result_count = 0;
  int              cycle_count  = 0;

  hamming_encode_and_syndrome DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .odd_parity     (odd_parity),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .digit_count    (digit_count),
    .data_value     (data_value),
    .received_word  (received_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_word      (code_word),
    .error_position (error_position),
    .code_length    (code_length)
  );

  always #10 clk = ~clk;

  function automatic bit group_fails(logic [CODE_W-1:0] word, int len, int k, bit odd);
    bit ones;
    ones = 1'b0;
    for (int p = 1; p <= len; p++) begin
      if (((p >> k) & 1) != 0) ones ^= word[p-1];
    end
    return ones ^ odd;
  endfunction

  function automatic hamming_result_t encode_or_check(op_t o, logic [DIGIT_W-1:0] digits,
                                                      logic [DATA_W-1:0] data,
                                                      logic [CODE_W-1:0] recv, bit odd);
    int              d;
    int              nbits;
    int              checks;
    int              len;
    int              idx;
    logic [CODE_W-1:0] word;
    logic [POS_W-1:0]  syn;
    hamming_result_t res;
    d = int'(digits);
    if (d < 1) d = 1;
    if (d > NIBBLES) d = NIBBLES;
    nbits  = 4 * d;
    checks = 0;
    while ((1 << checks) < nbits + checks + 1) checks++;
    len  = nbits + checks;
    word = '0;
    syn  = '0;
    if (o == OP_ENCODE) begin
      idx = 0;
      for (int p = 1; p <= len; p++) begin
        if ((p & (p - 1)) != 0) begin
          word[p-1] = data[idx];
          idx++;
        end
      end
      for (int k = 0; k < checks; k++) begin
        if (group_fails(word, len, k, odd)) word[(1 << k) - 1] = 1'b1;
      end
    end else begin
      for (int k = 0; k < checks; k++) begin
        if (group_fails(recv, len, k, odd)) syn[k] = 1'b1;
      end
    end
    res.code_word      = word;
    res.error_position = syn;
    res.code_length    = POS_W'(len);
    return res;
  endfunction

  task automatic report_field(string field, logic [CODE_W-1:0] want, logic [CODE_W-1:0] seen);
    if (want !== seen) begin
      if (fail_count < SHOWN_MAX)
        $display("result %0d %s: expected %h, got %h", result_count, field, want, seen);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hamming_encode_and_syndrome: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) parity_odd = odd_parity;
      if (in_valid && in_ready)
        results_due = {results_due, encode_or_check(op_t'(op), digit_count, data_value,
                                                    received_word, parity_odd)};
      if (out_valid && out_ready) begin
        got_result = '{code_word, error_position, code_length};
        if (results_due.size() == 0) begin
          if (fail_count < SHOWN_MAX)
            $display("result %0d arrived with nothing outstanding: %h", result_count,
                     got_result);
          fail_count++;
        end else begin
          due_result = results_due.pop_front();
          report_field("code_word", due_result.code_word, got_result.code_word);
          report_field("error_position", CODE_W'(due_result.error_position),
                       CODE_W'(got_result.error_position));
          report_field("code_length", CODE_W'(due_result.code_length),
                       CODE_W'(got_result.code_length));
        end
        result_count++;
      end
    end
  end

  task automatic send_request(op_t o, logic [DIGIT_W-1:0] d, logic [DATA_W-1:0] data,
                              logic [CODE_W-1:0] recv);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    op            <= o;
    digit_count   <= d;
    data_value    <= data;
    received_word <= recv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_parity(bit odd);
    drain();
    @(negedge clk);
    cfg_valid  <= 1'b1;
    odd_parity <= odd;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_extremes;
    hamming_result_t enc;
    logic [CODE_W-1:0] word;
    logic [DATA_W-1:0] data;
    send_request(OP_ENCODE, 4'd0,  '1, '0);
    send_request(OP_ENCODE, 4'd1,  '1, '1);
    send_request(OP_ENCODE, 4'd8,  '1, '0);
    send_request(OP_ENCODE, 4'd9,  '1, '1);
    send_request(OP_ENCODE, 4'd15, '1, '0);
    send_request(OP_ENCODE, 4'd0,  '0, '1);
    send_request(OP_ENCODE, 4'd1,  '0, '0);
    send_request(OP_ENCODE, 4'd8,  '0, '1);
    send_request(OP_ENCODE, 4'd9,  '0, '0);
    send_request(OP_ENCODE, 4'd15, '0, '1);
    send_request(OP_CHECK, 4'd8,  '1, '0);
    send_request(OP_CHECK, 4'd8,  '0, '1);
    send_request(OP_CHECK, 4'd1,  '0, '1);
    send_request(OP_CHECK, 4'd0,  '1, '1);
    send_request(OP_CHECK, 4'd15, '0, CODE_W'({$urandom, $urandom}));
    data = $urandom;
    enc  = encode_or_check(OP_ENCODE, 4'd8, data, '0, parity_odd);
    send_request(OP_CHECK, 4'd8, data, enc.code_word);
    word = enc.code_word;
    word[0] ^= 1'b1;
    send_request(OP_CHECK, 4'd8, data, word);
    word = enc.code_word;
    word[CODE_W-1] ^= 1'b1;
    send_request(OP_CHECK, 4'd8, data, word);
    word = enc.code_word;
    word[30] ^= 1'b1;
    word[31] ^= 1'b1;
    send_request(OP_CHECK, 4'd8, data, word);
  endtask

  task automatic test_mixed_traffic(int count);
    int                kind;
    int                flips;
    int                pos;
    logic [DIGIT_W-1:0] d;
    logic [DATA_W-1:0]  data;
    logic [CODE_W-1:0]  word;
    hamming_result_t    enc;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      d    = ($urandom_range(0, 99) < 85) ? DIGIT_W'($urandom_range(1, NIBBLES))
                                          : DIGIT_W'($urandom_range(0, 15));
      data = $urandom;
      if ($urandom_range(0, 9) == 0) data = $urandom_range(0, 1) ? '1 : '0;
      enc = encode_or_check(OP_ENCODE, d, data, '0, parity_odd);
      if (kind < 35) begin
        send_request(OP_ENCODE, d, data, CODE_W'({$urandom, $urandom}));
      end else if (kind < 85) begin
        word  = enc.code_word;
        flips = $urandom_range(0, 9);
        flips = (flips < 3) ? 0 : (flips < 8) ? 1 : 2;
        repeat (flips) begin
          pos = $urandom_range(1, int'(enc.code_length));
          word[pos-1] ^= 1'b1;
        end
        if ($urandom_range(0, 3) == 0)
          word |= CODE_W'({$urandom, $urandom}) & ~((CODE_W'(1) << enc.code_length) - 1'b1);
        send_request(OP_CHECK, d, $urandom, word);
      end else begin
        send_request(op_t'($urandom_range(0, 1)), DIGIT_W'($urandom_range(0, 15)), $urandom,
                     CODE_W'({$urandom, $urandom}));
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_mixed_traffic(count);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    set_parity(1'b0);
    test_directed_extremes();
    test_mixed_traffic(350);
    set_parity(1'b1);
    test_mixed_traffic(300);
    test_back_to_back(200);
    set_parity(1'b0);
    test_back_to_back(60);
    test_mixed_traffic(60);
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("hamming_encode_and_syndrome: match");
    end else begin
      $display("hamming_encode_and_syndrome: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hes_pkg.sv
rtl/hes_core.sv
rtl/hamming_encode_and_syndrome.sv
bench/tb_hamming_encode_and_syndrome.sv
